[design/dfd_pkg.sv]
// Shared constants, types and helpers for the downlink frame deframer.
package dfd_pkg;

	localparam int MAX_PAYLOAD  = 48;
	localparam int HEADER_BYTES = 7;
	localparam int DEPTH        = HEADER_BYTES + MAX_PAYLOAD + 1;
	localparam int PTR_W        = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 1'b1;

	localparam logic [7:0] MARKER_RST = 8'hA5;
	localparam logic [7:0] TYPE_RST   = 8'h02;

	// byte offsets inside a frame
	localparam logic [PTR_W-1:0] OFF_MARKER  = PTR_W'(0);
	localparam logic [PTR_W-1:0] OFF_TYPE    = PTR_W'(1);
	localparam logic [PTR_W-1:0] OFF_ADDR_HI = PTR_W'(2);
	localparam logic [PTR_W-1:0] OFF_ADDR_LO = PTR_W'(3);
	localparam logic [PTR_W-1:0] OFF_LEN_HI  = PTR_W'(5);
	localparam logic [PTR_W-1:0] OFF_LEN_LO  = PTR_W'(6);
	localparam logic [PTR_W-1:0] OFF_BODY    = PTR_W'(HEADER_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_MARK,
		ST_TYPE,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_SUM,
		ST_ADDR_HI,
		ST_ADDR_LO,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	typedef struct packed {
		logic             append;
		logic             rd_en;
		logic             rd_next;
		logic [PTR_W-1:0] rd_off;
		logic             pos_set;
		logic             pos_inc;
		logic             drop_one;
		logic             drop_frame;
		logic             len_hi_ld;
		logic             frame_ld;
		logic             sum_clr;
		logic             sum_acc;
		logic             addr_hi_ld;
		logic             addr_lo_ld;
		logic             out_ld;
		logic             out_empty;
	} cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic hdr_short;
		logic marker_hit;
		logic type_hit;
		logic len_bad;
		logic frame_short;
		logic sum_end;
		logic sum_ok;
		logic emit_last;
		logic len_zero;
		logic out_free;
	} stat_t;

	// modulo DEPTH for a sum of two values, one below DEPTH and the other at most DEPTH
	function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W:0] s);
		logic [PTR_W:0] r;
		r = (s >= (PTR_W+1)'(DEPTH)) ? s - (PTR_W+1)'(DEPTH) : s;
		return r[PTR_W-1:0];
	endfunction

endpackage

[design/dfd_datapath.sv]
// Deframer datapath: circular window memory, header and checksum registers, result register.
module dfd_datapath
	import dfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                st,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic [7:0]           rx_byte,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [15:0]          dest_address,
	output logic [7:0]           payload_byte,
	output logic                 byte_present,
	output logic                 frame_last
);

	logic [7:0]       win_mem [DEPTH];
	logic [7:0]       rd_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [7:0]       marker_q;
	logic [7:0]       type_q;
	logic [7:0]       len_hi_q;
	logic [CNT_W-1:0] flen_q;
	logic [7:0]       xor_q;
	logic [PTR_W-1:0] pos_q;
	logic [15:0]      addr_q;
	logic             out_valid_q;
	logic [15:0]      dest_q;
	logic [7:0]       byte_q;
	logic             present_q;
	logic             last_q;

	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] rd_off;
	logic [PTR_W-1:0] rd_addr;
	logic [CNT_W-1:0] drop_cnt;
	logic [15:0]      cand_len;
	logic [CNT_W-1:0] cand_flen;
	logic [CNT_W-1:0] pos_ext;

	assign tail     = wrap_ptr({1'b0, head_q} + (PTR_W+1)'(fill_q));
	assign rd_off   = cmd.rd_next ? pos_q + PTR_W'(1) : cmd.rd_off;
	assign rd_addr  = wrap_ptr({1'b0, head_q} + {1'b0, rd_off});
	assign drop_cnt = cmd.drop_frame ? flen_q : CNT_W'(1);
	assign cand_len = {len_hi_q, rd_q};
	// only meaningful once the length passed the bound check
	assign cand_flen = CNT_W'(cand_len) + CNT_W'(HEADER_BYTES + 1);
	assign pos_ext  = CNT_W'(pos_q);

	always_comb begin
		st.fill_zero   = (fill_q == '0);
		st.hdr_short   = (fill_q < CNT_W'(HEADER_BYTES));
		st.marker_hit  = (rd_q == marker_q);
		st.type_hit    = (rd_q == type_q);
		st.len_bad     = (cand_len > 16'(MAX_PAYLOAD));
		st.frame_short = (fill_q < cand_flen);
		st.sum_end     = (pos_ext == flen_q - CNT_W'(1));
		st.sum_ok      = (xor_q == rd_q);
		st.emit_last   = (pos_ext == flen_q - CNT_W'(2));
		st.len_zero    = (flen_q == CNT_W'(HEADER_BYTES + 1));
		st.out_free    = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			win_mem[tail] <= rx_byte;
		end
		if (cmd.rd_en) begin
			rd_q <= win_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			fill_q   <= '0;
			marker_q <= MARKER_RST;
			type_q   <= TYPE_RST;
		end else begin
			if (cmd.append) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.drop_one || cmd.drop_frame) begin
				head_q <= wrap_ptr({1'b0, head_q} + (PTR_W+1)'(drop_cnt));
				fill_q <= fill_q - drop_cnt;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MARKER: marker_q <= cfg_data;
					REG_TYPE:   type_q   <= cfg_data;
					default:    ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.len_hi_ld) begin
			len_hi_q <= rd_q;
		end
		if (cmd.frame_ld) begin
			flen_q <= cand_flen;
		end
		if (cmd.sum_clr) begin
			xor_q <= '0;
		end else if (cmd.sum_acc) begin
			xor_q <= xor_q ^ rd_q;
		end
		if (cmd.pos_set) begin
			pos_q <= cmd.rd_off;
		end else if (cmd.pos_inc) begin
			pos_q <= pos_q + PTR_W'(1);
		end
		if (cmd.addr_hi_ld) begin
			addr_q[15:8] <= rd_q;
		end
		if (cmd.addr_lo_ld) begin
			addr_q[7:0] <= rd_q;
		end
		if (cmd.out_ld) begin
			dest_q    <= addr_q;
			byte_q    <= cmd.out_empty ? 8'h00 : rd_q;
			present_q <= !cmd.out_empty;
			last_q    <= cmd.out_empty || st.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign dest_address = dest_q;
	assign payload_byte = byte_q;
	assign byte_present = present_q;
	assign frame_last   = last_q;

endmodule

[design/dfd_ctrl.sv]
// Deframer controller: parse sequencer over the buffered window.
module dfd_ctrl
	import dfd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.append = 1'b1;
					state_d    = ST_START;
				end
			end
			ST_START: begin
				if (st.fill_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = OFF_MARKER;
					state_d    = ST_MARK;
				end
			end
			ST_MARK: begin
				priority if (!st.marker_hit) begin
					cmd.drop_one = 1'b1;
					state_d      = ST_START;
				end else if (st.hdr_short) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = OFF_TYPE;
					state_d    = ST_TYPE;
				end
			end
			ST_TYPE: begin
				if (!st.type_hit) begin
					cmd.drop_one = 1'b1;
					state_d      = ST_START;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = OFF_LEN_HI;
					state_d    = ST_LEN_HI;
				end
			end
			ST_LEN_HI: begin
				cmd.len_hi_ld = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_off    = OFF_LEN_LO;
				state_d       = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				priority if (st.len_bad) begin
					cmd.drop_one = 1'b1;
					state_d      = ST_START;
				end else if (st.frame_short) begin
					state_d = ST_IDLE;
				end else begin
					cmd.frame_ld = 1'b1;
					cmd.sum_clr  = 1'b1;
					cmd.pos_set  = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_off   = OFF_MARKER;
					state_d      = ST_SUM;
				end
			end
			ST_SUM: begin
				// one byte per cycle; the last byte read is the checksum itself
				priority if (st.sum_end && st.sum_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_off = OFF_ADDR_HI;
					state_d    = ST_ADDR_HI;
				end else if (st.sum_end) begin
					cmd.drop_one = 1'b1;
					state_d      = ST_START;
				end else begin
					cmd.sum_acc = 1'b1;
					cmd.pos_inc = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
				end
			end
			ST_ADDR_HI: begin
				cmd.addr_hi_ld = 1'b1;
				cmd.rd_en      = 1'b1;
				cmd.rd_off     = OFF_ADDR_LO;
				state_d        = ST_ADDR_LO;
			end
			ST_ADDR_LO: begin
				cmd.addr_lo_ld = 1'b1;
				if (st.len_zero) begin
					state_d = ST_EMPTY;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_off  = OFF_BODY;
					cmd.pos_set = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.out_ld = 1'b1;
					if (st.emit_last) begin
						cmd.drop_frame = 1'b1;
						state_d        = ST_START;
					end else begin
						cmd.pos_inc = 1'b1;
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_EMPTY: begin
				if (st.out_free) begin
					cmd.out_ld     = 1'b1;
					cmd.out_empty  = 1'b1;
					cmd.drop_frame = 1'b1;
					state_d        = ST_START;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[design/downlink_frame_deframer.sv]
// Downlink frame deframer top level: controller, datapath and checks.
// Bytes enter one per transfer into a 56-byte circular window; after every byte the
// parser rescans from the window head. in_ready is high only while the parser is
// waiting for more data. The rescan reads one window memory byte per header field,
// with the read data registered, and drops non-marker bytes and rejected markers on
// the way. A complete frame of L payload bytes goes through header check, a checksum
// over its L+8 bytes (one window byte per cycle), address fetch and then one result
// item per payload byte (one for an empty frame), held while out_ready is low.
// Result items leave through a one-deep output register, and the window needs no
// clearing after reset.
module downlink_frame_deframer
	import dfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          dest_address,
	output logic [7:0]           payload_byte,
	output logic                 byte_present,
	output logic                 frame_last
);

	cmd_t  cmd;
	stat_t st;

	dfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	dfd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.dest_address (dest_address),
		.payload_byte (payload_byte),
		.byte_present (byte_present),
		.frame_last   (frame_last)
	);

	// a transfer in always starts a rescan, so ready is low in the cycle after it
	a_rescan_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an input transfer");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> st.out_free)
		else $error("result register loaded while occupied");

	// window pointers move one way at a time
	a_one_window_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.append, cmd.drop_one, cmd.drop_frame}))
		else $error("conflicting window updates");

	// a frame is consumed exactly when its final item is loaded
	a_last_drops_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld && (cmd.out_empty || st.emit_last) |-> cmd.drop_frame)
		else $error("final item loaded without consuming the frame");

endmodule

[bench/downlink_frame_deframer_test.sv]
// Testbench for the downlink frame deframer: byte stream driver, result sink, scoreboard.
module downlink_frame_deframer_test
	import dfd_pkg::*;
();

	localparam int SETTLE_CYCLES = 4000;
	localparam int LONG_HOLD     = 600;

	typedef struct packed {
		logic [15:0] addr;
		logic [7:0]  data;
		logic        present;
		logic        last;
	} deframed_t;

	// Tracks the byte window and the deframed items still owed by the block.
	class downlink_tracker;
		logic [7:0] marker;
		logic [7:0] dl_type;
		logic [7:0] rx_window[$];
		deframed_t  deframed_due[$];
		int         fails;

		function new();
			marker  = MARKER_RST;
			dl_type = TYPE_RST;
			fails   = 0;
		endfunction

		function void absorb_byte(logic [7:0] b);
			logic [15:0] blen;
			logic [15:0] addr;
			logic [7:0]  sum;
			int          flen;
			deframed_t   item;
			if (rx_window.size() >= DEPTH)
				void'(rx_window.pop_front());
			rx_window.insert(rx_window.size(), b);
			while (rx_window.size() > 0) begin
				if (rx_window[0] != marker) begin
					void'(rx_window.pop_front());
					continue;
				end
				if (rx_window.size() < HEADER_BYTES)
					break;
				if (rx_window[1] != dl_type) begin
					void'(rx_window.pop_front());
					continue;
				end
				blen = {rx_window[5], rx_window[6]};
				if (blen > MAX_PAYLOAD) begin
					void'(rx_window.pop_front());
					continue;
				end
				flen = HEADER_BYTES + int'(blen) + 1;
				if (rx_window.size() < flen)
					break;
				// checksum covers marker through the last payload byte
				sum = 8'h00;
				for (int i = 0; i < flen - 1; i++)
					sum ^= rx_window[i];
				if (sum != rx_window[flen-1]) begin
					void'(rx_window.pop_front());
					continue;
				end
				addr = {rx_window[2], rx_window[3]};
				if (blen == 0) begin
					item = {addr, 8'h00, 1'b0, 1'b1};
					deframed_due.insert(deframed_due.size(), item);
				end else begin
					for (int i = 0; i < int'(blen); i++) begin
						item = {addr, rx_window[HEADER_BYTES+i], 1'b1, 1'(i == int'(blen) - 1)};
						deframed_due.insert(deframed_due.size(), item);
					end
				end
				repeat (flen) void'(rx_window.pop_front());
			end
		endfunction

		function void match_item(deframed_t got);
			deframed_t want;
			if (deframed_due.size() == 0) begin
				$display("%0t: result with nothing pending: addr %h byte %h present %b last %b",
					$time, got.addr, got.data, got.present, got.last);
				fails++;
				return;
			end
			want = deframed_due.pop_front();
			if (got.addr !== want.addr) begin
				$display("%0t: dest_address expected %h, actual %h", $time, want.addr, got.addr);
				fails++;
			end
			if (got.data !== want.data) begin
				$display("%0t: payload_byte expected %h, actual %h", $time, want.data, got.data);
				fails++;
			end
			if (got.present !== want.present) begin
				$display("%0t: byte_present expected %b, actual %b", $time, want.present,
					got.present);
				fails++;
			end
			if (got.last !== want.last) begin
				$display("%0t: frame_last expected %b, actual %b", $time, want.last, got.last);
				fails++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [15:0]          dest_address;
	logic [7:0]           payload_byte;
	logic                 byte_present;
	logic                 frame_last;

	downlink_tracker board;
	logic [7:0]      tx_bytes[$];
	bit              calm = 1'b0;
	bit              hold_req = 1'b0;

	downlink_frame_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dest_address (dest_address),
		.payload_byte (payload_byte),
		.byte_present (byte_present),
		.frame_last   (frame_last)
	);

	always #10 clk = ~clk;

	// Queues one byte at the end of the outgoing stream.
	function automatic void stage_byte(input logic [7:0] b);
		tx_bytes.insert(tx_bytes.size(), b);
	endfunction

	// Appends one frame in the current format; oversize lengths get a short random tail.
	function automatic void add_frame(input logic [7:0] ty, input logic [15:0] addr,
			input logic [15:0] blen, input bit bad_sum);
		int         head;
		int         body;
		logic [7:0] sum;
		head = tx_bytes.size();
		body = (blen > MAX_PAYLOAD) ? $urandom_range(0, 4) : int'(blen);
		stage_byte(board.marker);
		stage_byte(ty);
		stage_byte(addr[15:8]);
		stage_byte(addr[7:0]);
		stage_byte(8'($urandom));
		stage_byte(blen[15:8]);
		stage_byte(blen[7:0]);
		repeat (body) stage_byte(8'($urandom));
		sum = 8'h00;
		for (int i = head; i < tx_bytes.size(); i++)
			sum ^= tx_bytes[i];
		if (bad_sum)
			sum ^= 8'($urandom_range(1, 255));
		stage_byte(sum);
	endfunction

	task automatic send_burst();
		bit quiet;
		quiet = calm || ($urandom_range(0, 2) == 0);
		foreach (tx_bytes[i]) begin
			in_valid <= 1'b1;
			rx_byte  <= tx_bytes[i];
			do @(posedge clk); while (in_ready !== 1'b1);
			board.absorb_byte(tx_bytes[i]);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
		tx_bytes.delete();
	endtask

	task automatic random_traffic(input int n_bytes);
		int          sent;
		int          pick;
		int          cut;
		logic [15:0] blen;
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(0, 4) != 0)
				blen = 16'($urandom_range(0, 8));
			else
				blen = 16'($urandom_range(9, MAX_PAYLOAD));
			if ($urandom_range(0, 9) == 0)
				blen = 16'(MAX_PAYLOAD);
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				add_frame(board.dl_type, 16'($urandom), blen, 1'b0);
			end else if (pick == 13) begin
				add_frame(board.dl_type ^ 8'($urandom_range(1, 255)), 16'($urandom), blen, 1'b0);
			end else if (pick == 14) begin
				add_frame(board.dl_type, 16'($urandom), blen, 1'b1);
			end else if (pick == 15) begin
				add_frame(board.dl_type, 16'($urandom),
					16'($urandom_range(MAX_PAYLOAD + 1, 65535)), 1'b0);
			end else if (pick == 16) begin
				repeat ($urandom_range(1, 6)) stage_byte(8'($urandom));
			end else if (pick == 17) begin
				// cut-off frame, the next frame lands inside it
				add_frame(board.dl_type, 16'($urandom), blen, 1'b0);
				cut = $urandom_range(1, tx_bytes.size() - 1);
				repeat (cut) void'(tx_bytes.pop_back());
			end else begin
				stage_byte(board.marker);
				add_frame(board.dl_type, 16'($urandom), blen, 1'b0);
			end
			sent += tx_bytes.size();
			send_burst();
		end
	endtask

	// Waits for every owed item, then lets the parser finish any rescan.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.deframed_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_format(input logic [7:0] mk, input logic [7:0] ty);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MARKER;
		cfg_data  <= mk;
		@(posedge clk);
		board.marker = mk;
		cfg_index <= REG_TYPE;
		cfg_data  <= ty;
		@(posedge clk);
		board.dl_type = ty;
		cfg_we <= 1'b0;
	endtask

	initial begin : result_sink
		int        stall_left;
		int        quiet_left;
		int        pick;
		deframed_t got;
		stall_left = 0;
		quiet_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				got = {dest_address, payload_byte, byte_present, frame_last};
				board.match_item(got);
			end
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
			end else if (calm) begin
				stall_left = 0;
			end else if (stall_left == 0 && quiet_left == 0) begin
				pick = $urandom_range(0, 39);
				if (pick < 5)
					stall_left = $urandom_range(1, 17);
				else if (pick == 5)
					quiet_left = $urandom_range(20, 200);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (quiet_left > 0)
					quiet_left--;
			end
		end
	end

	initial begin
		#60_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		board = new();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MARKER;
		cfg_data  <= 8'h00;
		in_valid  <= 1'b0;
		rx_byte   <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte, empty frame, wrong type, bad checksum, one-byte frame
		stage_byte(8'h00);
		add_frame(board.dl_type, 16'hFFFF, 16'd0, 1'b0);
		stage_byte(board.marker);
		stage_byte(~board.dl_type);
		add_frame(board.dl_type, 16'h0000, 16'd0, 1'b1);
		add_frame(board.dl_type, 16'h0000, 16'd1, 1'b0);
		send_burst();

		// long receiver hold while bytes keep coming
		hold_req = 1'b1;
		random_traffic(150);
		settle();

		set_format(8'h00, 8'h00);
		random_traffic(80);
		settle();

		set_format(8'hFF, 8'hFF);
		random_traffic(80);
		settle();

		set_format(8'($urandom), 8'($urandom));
		random_traffic(80);
		settle();

		set_format(MARKER_RST, TYPE_RST);
		calm = 1'b1;
		random_traffic(110);
		settle();

		if (board.fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
